/* sv/lpht_pkg.sv */
// Shared types, codes and defaults for the linear probing hash table.
// No dependencies; every other file imports this package.
package lpht_pkg;

    // Default sizing, handed to the top-level parameters.
    localparam int unsigned DEF_TABLE_DEPTH  = 1024;
    localparam int unsigned DEF_KEY_BITS     = 20;
    localparam int unsigned DEF_PAYLOAD_BITS = 32;

    // Fixed port field widths.
    localparam int unsigned KEY_W    = 20;
    localparam int unsigned PAY_W    = 32;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned SLOT_W   = 10;
    localparam int unsigned DATA_W   = 32;

    // Request kinds.
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    // Response status codes.
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

    typedef struct packed {
        logic             req_type;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } lpht_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [DATA_W-1:0]   data_out;
    } lpht_rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_step;
        logic load;
        logic mod_step;
        logic probe_start;
        logic probe_step;
        logic finish;
        logic out_load;
    } lpht_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic mod_done;
        logic probe_stop;
        logic probe_last;
    } lpht_sts_t;

endpackage

/* sv/lpht_dpath.sv */
// Datapath of the hash table: slot memory, home slot reduction, probe
// address and count registers, result and response registers. Uses lpht_pkg.
module lpht_dpath
    import lpht_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH  = DEF_TABLE_DEPTH,
    parameter int unsigned KEY_BITS     = DEF_KEY_BITS,
    parameter int unsigned PAYLOAD_BITS = DEF_PAYLOAD_BITS
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  lpht_req_t req,
    input  lpht_cmd_t cmd,
    output lpht_sts_t sts,
    output lpht_rsp_t rsp
);

    localparam int unsigned ADDR_W  = $clog2(TABLE_DEPTH);
    localparam int unsigned CNT_W   = 2;
    localparam int unsigned PROD_W  = 2 * KEY_BITS;
    localparam int unsigned CALC_W  = KEY_BITS + ADDR_W + 1;
    localparam int unsigned ENT_W   = 1 + KEY_BITS + PAYLOAD_BITS;
    localparam bit          IS_POW2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
    localparam logic [ADDR_W-1:0]   LAST_IDX  = ADDR_W'(TABLE_DEPTH - 1);
    localparam logic [CALC_W-1:0]   DEPTH_EXT = CALC_W'(TABLE_DEPTH);
    localparam logic [CNT_W-1:0]    MOD_STEPS = CNT_W'(3);
    localparam logic [KEY_BITS-1:0] RECIP     =
        KEY_BITS'((64'd1 << KEY_BITS) / TABLE_DEPTH);

    function automatic logic [ADDR_W-1:0] wrap_inc(input logic [ADDR_W-1:0] x);
        wrap_inc = (x == LAST_IDX) ? '0 : x + 1'b1;
    endfunction

    // Memory entry: valid mark, key, payload.
    logic [ENT_W-1:0] mem [TABLE_DEPTH];
    logic [ENT_W-1:0] rd_data_reg;

    logic                    req_type_reg;
    logic [KEY_BITS-1:0]     key_reg;
    logic [PAYLOAD_BITS-1:0] pay_reg;
    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic [CALC_W-1:0]       diff_reg, diff_next;
    logic [CNT_W-1:0]        mod_cnt_reg, mod_cnt_next;
    logic [ADDR_W-1:0]       rem_reg, rem_next;
    logic [ADDR_W-1:0]       cur_reg, cur_next;
    logic [ADDR_W-1:0]       nxt_reg, nxt_next;
    logic [ADDR_W-1:0]       cnt_reg, cnt_next;
    logic [ADDR_W-1:0]       clr_reg, clr_next;
    lpht_rsp_t               res_reg, res_next;
    lpht_rsp_t               rsp_reg;

    logic [63:0]             key_wide, pay_wide, home_wide, ent_pay_wide;
    logic [31:0]             cur_wide;
    logic [KEY_BITS-1:0]     key_in;
    logic [PAYLOAD_BITS-1:0] pay_in;
    logic [KEY_BITS-1:0]     q_est;
    logic [ADDR_W-1:0]       home;
    logic [ADDR_W-1:0]       rd_addr;
    logic                    rd_en;
    logic [ADDR_W-1:0]       wr_addr;
    logic [ENT_W-1:0]        wr_data;
    logic                    wr_en;
    logic                    ent_valid;
    logic [KEY_BITS-1:0]     ent_key;
    logic [PAYLOAD_BITS-1:0] ent_pay;
    logic                    ent_match;

    // Input fields reduced to the configured key and payload widths.
    assign key_wide = 64'(req.key);
    assign pay_wide = 64'(req.payload);
    assign key_in   = key_wide[KEY_BITS-1:0];
    assign pay_in   = pay_wide[PAYLOAD_BITS-1:0];

    // For a depth that is not a power of two the remainder takes three steps:
    // a quotient estimate by reciprocal multiplication, the key minus the
    // estimate times the depth, and one compare and subtract.
    assign q_est     = prod_reg[PROD_W-1:KEY_BITS];
    assign home_wide = 64'(key_reg);
    assign home      = IS_POW2 ? home_wide[ADDR_W-1:0] : rem_reg;

    assign ent_valid    = rd_data_reg[ENT_W-1];
    assign ent_key      = rd_data_reg[PAYLOAD_BITS +: KEY_BITS];
    assign ent_pay      = rd_data_reg[PAYLOAD_BITS-1:0];
    assign ent_match    = ent_valid && (ent_key == key_reg);
    assign ent_pay_wide = 64'(ent_pay);
    assign cur_wide     = 32'(cur_reg);

    assign sts.clr_last   = (clr_reg == LAST_IDX);
    assign sts.mod_done   = IS_POW2 || (mod_cnt_reg == '0);
    assign sts.probe_stop = !ent_valid || ent_match;
    assign sts.probe_last = (cnt_reg == LAST_IDX);

    assign rd_en   = cmd.probe_start || cmd.probe_step;
    assign rd_addr = cmd.probe_start ? home : nxt_reg;
    assign wr_en   = cmd.clr_step
                  || (cmd.finish && !ent_valid && (req_type_reg == REQ_INSERT));
    assign wr_addr = cmd.clr_step ? clr_reg : cur_reg;
    assign wr_data = cmd.clr_step ? '0 : {1'b1, key_reg, pay_reg};

    always_comb
    begin
        prod_next    = prod_reg;
        diff_next    = diff_reg;
        mod_cnt_next = mod_cnt_reg;
        rem_next     = rem_reg;
        cur_next     = cur_reg;
        nxt_next     = nxt_reg;
        cnt_next     = cnt_reg;
        clr_next     = clr_reg;
        res_next     = res_reg;
        if (cmd.clr_step)
        begin
            clr_next = wrap_inc(clr_reg);
        end
        if (cmd.load)
        begin
            mod_cnt_next = MOD_STEPS;
            rem_next     = '0;
        end
        if (cmd.mod_step && !sts.mod_done)
        begin
            mod_cnt_next = mod_cnt_reg - 1'b1;
            prod_next    = PROD_W'(key_reg) * PROD_W'(RECIP);
            diff_next    = CALC_W'(key_reg) - CALC_W'(q_est) * DEPTH_EXT;
            rem_next     = (diff_reg >= DEPTH_EXT) ? ADDR_W'(diff_reg - DEPTH_EXT)
                                                   : ADDR_W'(diff_reg);
        end
        if (cmd.probe_start)
        begin
            cur_next = home;
            nxt_next = wrap_inc(home);
            cnt_next = '0;
        end
        if (cmd.probe_step)
        begin
            cur_next = nxt_reg;
            nxt_next = wrap_inc(nxt_reg);
            cnt_next = cnt_reg + 1'b1;
        end
        if (cmd.finish)
        begin
            res_next = '0;
            if (req_type_reg == REQ_LOOKUP)
            begin
                if (ent_match)
                begin
                    res_next.status   = ST_FOUND;
                    res_next.slot     = cur_wide[SLOT_W-1:0];
                    res_next.data_out = ent_pay_wide[DATA_W-1:0];
                end
                else
                begin
                    res_next.status = ST_NOT_FOUND;
                end
            end
            else if (!ent_valid)
            begin
                res_next.status = ST_INSERTED;
                res_next.slot   = cur_wide[SLOT_W-1:0];
            end
            else if (ent_match)
            begin
                res_next.status = ST_DUPLICATE;
                res_next.slot   = cur_wide[SLOT_W-1:0];
            end
            else
            begin
                res_next.status = ST_FULL;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg     <= '0;
            mod_cnt_reg <= '0;
            cnt_reg     <= '0;
        end
        else
        begin
            clr_reg     <= clr_next;
            mod_cnt_reg <= mod_cnt_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_type_reg <= req.req_type;
            key_reg      <= key_in;
            pay_reg      <= pay_in;
        end
        prod_reg <= prod_next;
        diff_reg <= diff_next;
        rem_reg  <= rem_next;
        cur_reg  <= cur_next;
        nxt_reg  <= nxt_next;
        res_reg  <= res_next;
        if (cmd.out_load)
        begin
            rsp_reg <= res_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rsp = rsp_reg;

endmodule

/* sv/lpht_ctrl.sv */
// Controller of the hash table: clearing pass, request sequencing and the
// response valid flag. Uses lpht_pkg.
module lpht_ctrl
    import lpht_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    input  lpht_sts_t sts,
    output lpht_cmd_t cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_MOD   = 3'd2;
    localparam logic [2:0] S_START = 3'd3;
    localparam logic [2:0] S_PROBE = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       rsp_valid_reg, rsp_valid_next;
    logic       out_free;

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (sts.mod_done)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                cmd.probe_start = 1'b1;
                state_next      = S_PROBE;
            end
            S_PROBE:
            begin
                if (sts.probe_stop || sts.probe_last)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.probe_step = 1'b1;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

/* sv/linear_probe_hash_table_unit.sv */
// Linear probing hash table: one request at a time. A request passes through
// key reduction and the probe loop, and rsp_valid rises once its result is in
// the output register; the next request is taken only after that load.
// The probe loop reads one slot per cycle from the slot memory.
// After reset a clearing pass empties every slot; requests are not accepted
// until it ends.
module linear_probe_hash_table_unit
    import lpht_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH  = DEF_TABLE_DEPTH,
    parameter int unsigned KEY_BITS     = DEF_KEY_BITS,
    parameter int unsigned PAYLOAD_BITS = DEF_PAYLOAD_BITS
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  lpht_req_t req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output lpht_rsp_t rsp
);

    // The controller sequences each request through key reduction, the
    // probe loop and the response register. The datapath holds the slot
    // memory, whose entries carry a valid mark, the key and the payload.
    lpht_cmd_t cmd;
    lpht_sts_t sts;

    // The controller owns the handshake. A finished response waits in the
    // output register while the next request is already accepted.
    lpht_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // The datapath issues the read of the next slot while the current slot
    // is examined, so the probe loop advances one slot per cycle. An insert
    // writes its entry in the cycle its probe finds an empty slot.
    lpht_dpath #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .KEY_BITS     (KEY_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dpath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .sts   (sts),
        .rsp   (rsp)
    );

endmodule
